@@ hw/rtl/brfd_pkg.sv @@
// Package for the byte ring FIFO with drain: field widths, command and
// status codes, register indexes and the front-to-back command struct.
// No dependencies.
package brfd_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned CapW         = 7;
  localparam int unsigned FillW        = 6;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned LimitMax     = 64;

  localparam logic [CfgIdxW-1:0] CfgCapacity   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDrainLimit = 2'd1;

  typedef enum logic [1:0] {
    FuncPush  = 2'd0,
    FuncPop   = 2'd1,
    FuncDrain = 2'd2,
    FuncClear = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  typedef struct packed {
    func_e              func;
    logic [ByteW-1:0]   data;
  } cmd_t;

endpackage

@@ hw/rtl/brfd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module brfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/brfd_front.sv @@
// Front end: accepts commands from the input stream and holds them in a
// two-entry queue for the back end. Depends on brfd_pkg.
module brfd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  output logic                      s_ready_o,
  input  logic [1:0]                s_func_i,
  input  logic [brfd_pkg::ByteW-1:0] s_data_i,
  output logic                      q_valid_o,
  input  logic                      q_ready_i,
  output brfd_pkg::cmd_t            q_cmd_o
);
  import brfd_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign s_ready_o = (count_q != 2'd2);
  assign q_valid_o = (count_q != 2'd0);
  assign q_cmd_o   = slot_q[rd_ptr_q];

  assign push = s_valid_i && s_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified command
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q].func <= func_e'(s_func_i);
      slot_q[wr_ptr_q].data <= s_data_i;
    end
  end

endmodule

@@ hw/rtl/brfd_back.sv @@
// Back end: ring pointers, configuration registers, command sequencer and
// the output register; drives the byte store RAM. Depends on brfd_pkg, brfd_ram.
module brfd_back #(
  parameter int unsigned DEPTH = brfd_pkg::DepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [brfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [brfd_pkg::CapW-1:0]    cfg_data_i,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  brfd_pkg::cmd_t               q_cmd_i,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output logic [brfd_pkg::ByteW-1:0]   m_data_o,
  output logic [1:0]                   m_status_o,
  output logic [brfd_pkg::FillW-1:0]   m_fill_o,
  output logic                         m_last_o
);
  import brfd_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);

  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StData = 1'b1;

  logic [0:0]      state_q, state_d;
  logic [PW-1:0]   rp_q, rp_d, wp_q, wp_d;
  logic [CapW-1:0] left_q, left_d;
  logic [CapW-1:0] cap_q, limit_q;
  logic [CapW-1:0] cap_eff, limit_eff, fill_now, drain_n;
  logic            empty, full, out_free;

  logic             ram_we, ram_re;
  logic [ByteW-1:0] ram_rdata;

  logic             out_valid_q;
  logic [ByteW-1:0] out_data_q, ld_data;
  status_e          out_status_q, ld_status;
  logic [FillW-1:0] out_fill_q, ld_fill;
  logic             out_last_q, ld_last, ld;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CapW-1:0] cap);
    logic [CapW-1:0] n;
    n = CapW'(p) + CapW'(1);
    return (n >= cap) ? '0 : n[PW-1:0];
  endfunction

  // Clamp registers to their working ranges
  assign cap_eff   = (cap_q < CapW'(2)) ? CapW'(2) :
                     (cap_q > CapW'(DEPTH)) ? CapW'(DEPTH) : cap_q;
  assign limit_eff = (limit_q == '0) ? CapW'(1) :
                     (limit_q > CapW'(LimitMax)) ? CapW'(LimitMax) : limit_q;

  // Occupancy of the ring
  assign fill_now = (wp_q >= rp_q) ? (CapW'(wp_q) - CapW'(rp_q))
                                   : (cap_eff - CapW'(rp_q) + CapW'(wp_q));
  assign empty    = (rp_q == wp_q);
  assign full     = (adv(wp_q, cap_eff) == rp_q);
  assign drain_n  = (fill_now > limit_eff) ? limit_eff : fill_now;
  assign out_free = !out_valid_q || m_ready_i;

  // Sequence one command at a time; reads stream out one byte per cycle while the output is free
  always_comb begin
    state_d   = state_q;
    rp_d      = rp_q;
    wp_d      = wp_q;
    left_d    = left_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    q_ready_o = 1'b0;
    ld        = 1'b0;
    ld_data   = '0;
    ld_status = StatusOk;
    ld_fill   = FillW'(fill_now);
    ld_last   = 1'b1;
    case (state_q)
      StIdle: begin
        q_ready_o = out_free;
        if (q_valid_i && out_free) begin
          case (q_cmd_i.func)
            FuncPush: begin
              ld = 1'b1;
              if (full) begin
                ld_status = StatusFull;
              end else begin
                ram_we  = 1'b1;
                wp_d    = adv(wp_q, cap_eff);
                ld_fill = FillW'(fill_now + CapW'(1));
              end
            end
            FuncPop, FuncDrain: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = StatusEmpty;
                ld_fill   = '0;
              end else begin
                ram_re  = 1'b1;
                rp_d    = adv(rp_q, cap_eff);
                left_d  = (q_cmd_i.func == FuncPop) ? CapW'(1) : drain_n;
                state_d = StData;
              end
            end
            FuncClear: begin
              rp_d    = '0;
              wp_d    = '0;
              ld      = 1'b1;
              ld_fill = '0;
            end
            default: begin
              ld = 1'b0;
            end
          endcase
        end
      end
      StData: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_data = ram_rdata;
          ld_last = (left_q == CapW'(1));
          if (left_q == CapW'(1)) begin
            state_d = StIdle;
          end else begin
            left_d = left_q - CapW'(1);
            ram_re = 1'b1;
            rp_d   = adv(rp_q, cap_eff);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    // A capacity write empties the ring
    if (cfg_we_i && cfg_index_i == CfgCapacity) begin
      rp_d = '0;
      wp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rp_q        <= '0;
      wp_q        <= '0;
      left_q      <= '0;
      cap_q       <= CapW'(64);
      limit_q     <= CapW'(LimitMax);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      left_q  <= left_d;
      if (cfg_we_i && cfg_index_i == CfgCapacity) begin
        cap_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CfgDrainLimit) begin
        limit_q <= cfg_data_i;
      end
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until taken
  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_data_q   <= ld_data;
      out_status_q <= ld_status;
      out_fill_q   <= ld_fill;
      out_last_q   <= ld_last;
    end
  end

  brfd_ram #(
    .Width (ByteW),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (q_cmd_i.data),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  assign m_valid_o  = out_valid_q;
  assign m_data_o   = out_data_q;
  assign m_status_o = out_status_q;
  assign m_fill_o   = out_fill_q;
  assign m_last_o   = out_last_q;

endmodule

@@ hw/rtl/byte_ring_fifo_with_drain.sv @@
// Top level of the byte ring FIFO with drain: command front end, back end
// and checks. Depends on brfd_pkg, brfd_front, brfd_back, brfd_ram.
//
// Usage: each transfer on the slave stream is one command, carried in
// tuser (0 push, 1 pop, 2 drain, 3 clear) with the push byte in tdata.
// Every command yields one result on the master stream, except a drain of
// a non-empty ring, which yields one result per byte, up to the drain limit,
// oldest first; tlast marks the final result of each command. Result tdata
// carries the byte and the fill level, tuser the status (ok, full, empty).
// The config channel writes the ring capacity (index 0, also empties the
// ring) and the drain limit (index 1); write only while the block is idle.
// Flow: a command enters a two-entry queue and is executed from there;
// push, clear and empty results pass through the queue and the output
// register, pop and drain bytes also through the registered read of the
// byte store. Throughput is one command per cycle for push and clear, and
// one result per cycle during a drain, while the receiver is ready; a pop
// or drain of a non-empty ring holds the sequencer, which takes no new
// command until its last byte is loaded; a store read comes first.
// Reset empties the ring and loads capacity 64 and drain limit 64; no
// clearing pass is needed. A receiver stall holds the result register and
// backs up through the command queue to the slave tready.
module byte_ring_fifo_with_drain #(
  parameter int unsigned DEPTH = brfd_pkg::DepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [brfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [brfd_pkg::CapW-1:0]    cfg_data_i,
  // command stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // [7:0] data_in
  input  logic [1:0]                   s_axis_tuser_i,  // [1:0] func
  // result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [15:0]                  m_axis_tdata_o,  // [7:0] data_out, [13:8] fill_level
  output logic [1:0]                   m_axis_tuser_o,  // [1:0] status
  output logic                         m_axis_tlast_o
);
  import brfd_pkg::*;

  logic                 q_valid, q_ready;
  cmd_t                 q_cmd;
  logic [ByteW-1:0]     m_data;
  logic [FillW-1:0]     m_fill;

  assign cfg_ready_o = 1'b1;

  brfd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_func_i  (s_axis_tuser_i),
    .s_data_i  (s_axis_tdata_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_cmd_o   (q_cmd)
  );

  brfd_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_cmd_i     (q_cmd),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_data),
    .m_status_o  (m_axis_tuser_o),
    .m_fill_o    (m_fill),
    .m_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, m_fill, m_data};

  // A refused push is always a single, final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == StatusFull) |-> m_axis_tlast_o)
    else $error("full status without tlast");

  // An empty result carries no byte and reports an empty ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == StatusEmpty) |->
      (m_axis_tlast_o && m_axis_tdata_o == 16'd0))
    else $error("empty status with data or fill");

  // A byte is only returned with an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[7:0] != 8'd0) |-> (m_axis_tuser_o == StatusOk))
    else $error("data returned with error status");

endmodule
